/* src/cksm_pkg.sv */
package cksm_pkg;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_ROTARY = 2'd1;
	localparam logic [1:0] CMD_BUTTON = 2'd2;
	localparam logic [1:0] CMD_WRITE  = 2'd3;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_HOUR   = 2'd1;
	localparam logic [1:0] MODE_MINUTE = 2'd2;

	localparam logic [0:0] REG_ROTARY_GUARD = 1'd0;
	localparam logic [0:0] REG_BUTTON_GUARD = 1'd1;

	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [5:0] SECOND_MAX = 6'd59;

	localparam logic [15:0] ROTARY_GUARD_RESET = 16'd150;
	localparam logic [15:0] BUTTON_GUARD_RESET = 16'd200;

	typedef struct packed {
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [1:0]  mode;
		logic [31:0] rot_stamp;
		logic [31:0] btn_stamp;
	} cksm_state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        phase_b_level;
		logic [31:0] now_ms;
		logic [4:0]  new_hours;
		logic [5:0]  new_minutes;
		logic [5:0]  new_seconds;
	} cksm_item_t;

	typedef struct packed {
		logic commit_time;
		logic event_taken;
	} cksm_flags_t;

endpackage

/* src/cksm_step.sv */
module cksm_step (
	input  cksm_pkg::cksm_state_t cur,
	input  cksm_pkg::cksm_item_t  item,
	input  logic [15:0]           rotary_guard_ms,
	input  logic [15:0]           button_guard_ms,
	output cksm_pkg::cksm_state_t nxt,
	output cksm_pkg::cksm_flags_t flags
);
	import cksm_pkg::*;

	logic [31:0] rot_diff;
	logic [31:0] btn_diff;
	logic        rot_ok;
	logic        btn_ok;

	// wrap-safe "strictly after stamp + guard"
	assign rot_diff = item.now_ms - cur.rot_stamp - {16'd0, rotary_guard_ms};
	assign btn_diff = item.now_ms - cur.btn_stamp - {16'd0, button_guard_ms};
	assign rot_ok   = (rot_diff != 32'd0) && !rot_diff[31];
	assign btn_ok   = (btn_diff != 32'd0) && !btn_diff[31];

	always_comb begin
		nxt   = cur;
		flags = '0;
		case (item.cmd)
			CMD_TICK: begin
				if (cur.mode == MODE_NORMAL) begin
					if (cur.seconds >= SECOND_MAX) begin
						nxt.seconds = '0;
						if (cur.minutes >= MINUTE_MAX) begin
							nxt.minutes = '0;
							nxt.hours   = (cur.hours >= HOUR_MAX) ? 5'd0 : cur.hours + 5'd1;
						end else begin
							nxt.minutes = cur.minutes + 6'd1;
						end
					end else begin
						nxt.seconds = cur.seconds + 6'd1;
					end
				end
			end
			CMD_ROTARY: begin
				if (rot_ok) begin
					nxt.rot_stamp     = item.now_ms;
					flags.event_taken = 1'b1;
					if (cur.mode == MODE_HOUR) begin
						if (item.phase_b_level)
							nxt.hours = (cur.hours == 5'd0 || cur.hours > HOUR_MAX) ?
								HOUR_MAX : cur.hours - 5'd1;
						else
							nxt.hours = (cur.hours >= HOUR_MAX) ? 5'd0 : cur.hours + 5'd1;
						flags.commit_time = 1'b1;
					end else if (cur.mode == MODE_MINUTE) begin
						if (item.phase_b_level)
							nxt.minutes = (cur.minutes == 6'd0 || cur.minutes > MINUTE_MAX) ?
								MINUTE_MAX : cur.minutes - 6'd1;
						else
							nxt.minutes = (cur.minutes >= MINUTE_MAX) ? 6'd0 : cur.minutes + 6'd1;
						nxt.seconds       = '0;
						flags.commit_time = 1'b1;
					end
				end
			end
			CMD_BUTTON: begin
				if (btn_ok) begin
					nxt.btn_stamp     = item.now_ms;
					flags.event_taken = 1'b1;
					nxt.mode          = (cur.mode >= MODE_MINUTE) ? MODE_NORMAL : cur.mode + 2'd1;
				end
			end
			default: begin
				nxt.hours   = (item.new_hours > HOUR_MAX) ? HOUR_MAX : item.new_hours;
				nxt.minutes = (item.new_minutes > MINUTE_MAX) ? MINUTE_MAX : item.new_minutes;
				nxt.seconds = (item.new_seconds > SECOND_MAX) ? SECOND_MAX : item.new_seconds;
				flags.commit_time = 1'b1;
			end
		endcase
	end

endmodule

/* src/clock_keeper_with_set_modes.sv */
// Clock keeper with set modes.
// Input stream (s_axis_*): one request per event. tuser carries the event kind
// (tick, rotary step, button press, time write); tdata carries the rotary phase,
// the millisecond timestamp and the time values for a write.
// Output stream (m_axis_*): exactly one result per request, in order: the time and
// mode after the event, a commit flag and a debounce-pass flag.
// Configuration: cfg_we/cfg_index/cfg_data set the rotary and button guard
// windows; write only while no request is in flight.
// A request accepted on s_axis is registered in the input register, and its result
// in the result register. Throughput: one request per cycle unless m_axis stalls.
// The event logic sits between the input register and the result register; the
// time and mode registers update in the same cycle the result is registered.
// Stall: while m_axis_tready is low the result holds, one more request may wait
// in the input register, and s_axis_tready then drops until the result is taken.
// Reset: time 00:00:00, normal mode, stamps zero, guards 150 ms and 200 ms,
// both stream stages empty.
module clock_keeper_with_set_modes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // phase_b_level, now_ms[32], new_hours[5],
	                                   // new_minutes[6], new_seconds[6], zero pad
	input  logic [1:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // hours_now[5], minutes_now[6], seconds_now[6],
	                                   // mode_now[2], commit_time, event_taken, zero pad
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cksm_pkg::*;

	logic                  valid_s1;
	cksm_item_t            item_s1;
	logic                  advance;
	cksm_state_t           state_q;
	cksm_state_t           state_nxt;
	cksm_flags_t           flags_nxt;
	logic [15:0]           rot_guard_q;
	logic [15:0]           btn_guard_q;
	logic                  out_valid_q;
	logic [20:0]           out_data_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd           <= s_axis_tuser;
			item_s1.phase_b_level <= s_axis_tdata[0];
			item_s1.now_ms        <= s_axis_tdata[32:1];
			item_s1.new_hours     <= s_axis_tdata[37:33];
			item_s1.new_minutes   <= s_axis_tdata[43:38];
			item_s1.new_seconds   <= s_axis_tdata[49:44];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_guard_q <= ROTARY_GUARD_RESET;
			btn_guard_q <= BUTTON_GUARD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROTARY_GUARD: rot_guard_q <= cfg_data;
				REG_BUTTON_GUARD: btn_guard_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cksm_step u_step (
		.cur             (state_q),
		.item            (item_s1),
		.rotary_guard_ms (rot_guard_q),
		.button_guard_ms (btn_guard_q),
		.nxt             (state_nxt),
		.flags           (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {flags_nxt.event_taken, flags_nxt.commit_time, state_nxt.mode,
				state_nxt.seconds, state_nxt.minutes, state_nxt.hours};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_data_q};

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode <= MODE_MINUTE)
		else $error("mode register reached an unused code");

	a_time_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hours <= HOUR_MAX && state_q.minutes <= MINUTE_MAX &&
		state_q.seconds <= SECOND_MAX)
		else $error("time register out of range");

	a_tick_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_TICK) |=> (out_data_q[20:19] == 2'b00))
		else $error("second tick raised commit or event flag");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> $stable(state_q))
		else $error("state advanced while result stalled");

endmodule
